/* sv/gfsbox_pkg.sv */
// shared constants and field arithmetic for the gf256 inverse and affine s-box
package gfsbox_pkg;

  localparam int unsigned NUM_STAGES = 14;   // value stages; last one holds x^254
  localparam int unsigned ADDR_W     = 4;

  localparam logic [7:0] RST_POLY_LOW     = 8'hCF;
  localparam logic [7:0] RST_AFFINE_ROW   = 8'hE3;
  localparam logic [7:0] RST_AFFINE_CONST = 8'h8D;

  typedef enum logic [1:0] {
    REG_POLY_LOW     = 2'd0,
    REG_AFFINE_ROW   = 2'd1,
    REG_AFFINE_CONST = 2'd2,
    REG_NONE         = 2'd3
  } reg_idx_t;

  typedef logic [7:0] byte_t;

  // product modulo 0x100 | poly, shift-and-add over the eight bits of b
  function automatic byte_t gf_mul(input byte_t a, input byte_t b, input byte_t poly);
    byte_t acc;
    byte_t sh;
    acc = '0;
    sh  = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) begin
        acc = acc ^ sh;
      end
      sh = sh[7] ? ((sh << 1) ^ poly) : (sh << 1);
    end
    return acc;
  endfunction

  // output bit i: parity of (row rotated left by i) and inv, plus const bit 7-i
  function automatic byte_t affine_map(input byte_t inv, input byte_t row, input byte_t cst);
    byte_t res;
    byte_t rot;
    res = '0;
    for (int i = 0; i < 8; i++) begin
      rot    = (row << i) | (row >> (8 - i));
      res[i] = (^(rot & inv)) ^ cst[7 - i];
    end
    return res;
  endfunction

endpackage

/* sv/gf256_inverse_affine_sbox_core.sv */
// gf256 inverse by power 254 followed by a configurable affine map, fully pipelined
// throughput: one word per cycle while the output is not stalled; an input register, a 13-stage square/multiply chain
// and an affine output stage, each stage at most one field multiply deep
// stalled stages hold; empty stages ahead of a stall keep filling (bubbles collapse)
// reset: synchronous, active high; clears all valid bits and loads the configuration registers with their defaults
module gf256_inverse_affine_sbox_core
  import gfsbox_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  // output channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic [7:0]          inv_byte,
  // register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // configuration registers
  byte_t poly_low;
  byte_t affine_row;
  byte_t affine_const;

  reg_idx_t reg_sel;
  logic     wr_en;

  // pipeline state: valid bit, running power of x, and x itself
  logic  v   [NUM_STAGES];
  byte_t r   [NUM_STAGES];
  byte_t xq  [NUM_STAGES];
  byte_t res [NUM_STAGES];
  logic  adv [NUM_STAGES];
  logic  out_adv;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[3:2]);
  assign wr_en   = psel & penable & pwrite & pready;

  // register writes; unknown index is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      poly_low     <= RST_POLY_LOW;
      affine_row   <= RST_AFFINE_ROW;
      affine_const <= RST_AFFINE_CONST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_POLY_LOW:     poly_low     <= pwdata[7:0];
        REG_AFFINE_ROW:   affine_row   <= pwdata[7:0];
        REG_AFFINE_CONST: affine_const <= pwdata[7:0];
        default:          ;
      endcase
    end
  end

  // register read-back, zero extended
  always_comb begin
    case (reg_sel)
      REG_POLY_LOW:     prdata = {24'd0, poly_low};
      REG_AFFINE_ROW:   prdata = {24'd0, affine_row};
      REG_AFFINE_CONST: prdata = {24'd0, affine_const};
      default:          prdata = '0;
    endcase
  end

  // ready chain: a stage may load when it is empty or its contents move on
  assign out_adv = ~out_valid | out_ready;

  always_comb begin
    adv[NUM_STAGES-1] = ~v[NUM_STAGES-1] | out_adv;
    for (int j = NUM_STAGES - 2; j >= 0; j--) begin
      adv[j] = ~v[j] | adv[j+1];
    end
  end

  assign in_ready = adv[0];

  // stage work: stage 0 loads x, odd stages square, later even stages multiply by x
  // chain of powers: x, 2, 3, 6, 7, 14, 15, 30, 31, 62, 63, 126, 127, 254
  always_comb begin
    res[0] = in_byte;
    for (int j = 1; j < NUM_STAGES; j++) begin
      if ((j % 2) == 1) begin
        res[j] = gf_mul(r[j-1], r[j-1], poly_low);
      end else begin
        res[j] = gf_mul(r[j-1], xq[j-1], poly_low);
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < NUM_STAGES; j++) begin
        v[j] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else begin
      if (adv[0]) begin
        v[0] <= in_valid;
      end
      for (int j = 1; j < NUM_STAGES; j++) begin
        if (adv[j]) begin
          v[j] <= v[j-1];
        end
      end
      if (out_adv) begin
        out_valid <= v[NUM_STAGES-1];
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (adv[0] && in_valid) begin
      r[0]  <= res[0];
      xq[0] <= in_byte;
    end
    for (int j = 1; j < NUM_STAGES; j++) begin
      if (adv[j] && v[j-1]) begin
        r[j]  <= res[j];
        xq[j] <= xq[j-1];
      end
    end
    if (out_adv && v[NUM_STAGES-1]) begin
      inv_byte <= r[NUM_STAGES-1];
      out_byte <= affine_map(r[NUM_STAGES-1], affine_row, affine_const);
    end
  end

endmodule

/* sv/gfsbox_checker.sv */
// port-level checks for the s-box core, bound to the top level
module gfsbox_checker
  import gfsbox_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic [7:0] inv_byte,
  input logic       pready
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  // input is refused only when every stage is full behind a stalled output word
  a_refuse_only_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input refused without a stalled output word");

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(inv_byte))
    else $error("output word changed while stalled");

  // register port never inserts wait states
  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind gf256_inverse_affine_sbox_core gfsbox_checker u_gfsbox_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_byte  (out_byte),
  .inv_byte  (inv_byte),
  .pready    (pready)
);
